[design/hpg_pkg.sv]
`timescale 1ns / 1ps
// shared types, command codes and digit weight functions for the halton point generator
package hpg_pkg;

  localparam int TERN_BASE = 3;
  localparam int QUIN_BASE = 5;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_SEEK = 1'b1;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_INC,
    CELL_DOUBLE,
    CELL_ROTATE
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SUM
  } seq_state_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       shift_bit;
  } chain_ctl_t;

  // floor(2^frac_bits / base^(pos+1)) by repeated division by the base
  function automatic logic [31:0] digit_weight(input logic is_quin, input int frac_bits,
                                               input int pos);
    logic [32:0] w;
    w = 33'(1) << frac_bits;
    for (int i = 0; i <= pos; i++) begin
      if (is_quin) begin
        w = w / QUIN_BASE;
      end else begin
        w = w / TERN_BASE;
      end
    end
    return w[31:0];
  endfunction

  // sum change when position pos takes the increment and all below it wrap to zero;
  // pos equal to digits means the carry leaves the top digit
  function automatic logic [31:0] carry_delta(input logic is_quin, input int frac_bits,
                                              input int pos, input int digits);
    logic [31:0] acc;
    logic [31:0] dmax;
    acc  = 32'd0;
    dmax = is_quin ? 32'(QUIN_BASE - 1) : 32'(TERN_BASE - 1);
    for (int i = 0; i < pos; i++) begin
      acc = acc - dmax * digit_weight(is_quin, frac_bits, i);
    end
    if (pos < digits) begin
      acc = acc + digit_weight(is_quin, frac_bits, pos);
    end
    return acc;
  endfunction

endpackage

[design/hpg_digit_cell.sv]
`timescale 1ns / 1ps
// one digit of a base-b counter: increment with carry, double-and-add, rotate, clear
module hpg_digit_cell #(
  parameter int BASE    = 3,
  parameter int DIGIT_W = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hpg_pkg::cell_mode_t  mode,
  input  logic                 cin,
  input  logic [DIGIT_W-1:0]   nbr_digit,
  output logic [DIGIT_W-1:0]   digit,
  output logic                 cout,
  output logic                 bump
);
  import hpg_pkg::*;

  localparam logic [DIGIT_W-1:0] DMAX   = DIGIT_W'(BASE - 1);
  localparam logic [DIGIT_W:0]   BASE_V = (DIGIT_W + 1)'(BASE);

  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic [DIGIT_W:0]   dbl;

  always_comb begin
    dbl       = {digit_r, 1'b0} + {{DIGIT_W{1'b0}}, cin};
    digit_nxt = digit_r;
    cout      = 1'b0;
    bump      = 1'b0;
    case (mode)
      CELL_CLEAR: begin
        digit_nxt = '0;
      end
      CELL_INC: begin
        if (cin) begin
          if (digit_r == DMAX) begin
            digit_nxt = '0;
            cout      = 1'b1;
          end else begin
            digit_nxt = digit_r + DIGIT_W'(1);
            bump      = 1'b1;
          end
        end
      end
      CELL_DOUBLE: begin
        // msb-first conversion: digit = 2*digit + incoming bit, carry on overflow
        if (dbl >= BASE_V) begin
          digit_nxt = DIGIT_W'(dbl - BASE_V);
          cout      = 1'b1;
        end else begin
          digit_nxt = dbl[DIGIT_W-1:0];
        end
      end
      CELL_ROTATE: begin
        digit_nxt = nbr_digit;
      end
      default: begin
        digit_nxt = digit_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= '0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

[design/hpg_digit_chain.sv]
`timescale 1ns / 1ps
// row of digit cells for one base with its running fixed-point coordinate sum
module hpg_digit_chain #(
  parameter int BASE      = 3,
  parameter int DIGITS    = 21,
  parameter int DIGIT_W   = 2,
  parameter int FRAC_BITS = 32,
  parameter int CNT_W     = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hpg_pkg::chain_ctl_t   ctl,
  input  logic [CNT_W-1:0]      cnt,
  output logic [FRAC_BITS-1:0]  sum
);
  import hpg_pkg::*;

  localparam int   IDX_W   = $clog2(DIGITS);
  localparam logic IS_QUIN = (BASE == QUIN_BASE);

  logic [FRAC_BITS-1:0] wt_tab    [DIGITS];
  logic [FRAC_BITS-1:0] delta_tab [DIGITS+1];

  logic [DIGIT_W-1:0] digit [DIGITS];
  logic [DIGITS-1:0]  carry;
  logic [DIGITS-1:0]  bump;
  logic               rot_en;
  cell_mode_t         cell_mode;

  logic [FRAC_BITS-1:0]         sum_r, sum_nxt;
  logic [FRAC_BITS-1:0]         delta_sel;
  logic [FRAC_BITS-1:0]         wt_sel;
  logic [FRAC_BITS+DIGIT_W-1:0] prod;

  for (genvar k = 0; k < DIGITS; k++) begin : g_tab
    assign wt_tab[k]    = FRAC_BITS'(digit_weight(IS_QUIN, FRAC_BITS, k));
    assign delta_tab[k] = FRAC_BITS'(carry_delta(IS_QUIN, FRAC_BITS, k, DIGITS));
  end
  assign delta_tab[DIGITS] = FRAC_BITS'(carry_delta(IS_QUIN, FRAC_BITS, DIGITS, DIGITS));

  // rotation runs only while cnt is below this row's digit count
  assign rot_en    = (cnt < CNT_W'(DIGITS));
  assign cell_mode = (ctl.mode == CELL_ROTATE && !rot_en) ? CELL_HOLD : ctl.mode;

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    logic                cin_k;
    logic [DIGIT_W-1:0]  nbr_k;
    if (k == 0) begin : g_first
      assign cin_k = (ctl.mode == CELL_INC) ? 1'b1 : ctl.shift_bit;
    end else begin : g_rest
      assign cin_k = carry[k-1];
    end
    assign nbr_k = digit[(k + 1) % DIGITS];

    hpg_digit_cell #(
      .BASE    (BASE),
      .DIGIT_W (DIGIT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .mode      (cell_mode),
      .cin       (cin_k),
      .nbr_digit (nbr_k),
      .digit     (digit[k]),
      .cout      (carry[k]),
      .bump      (bump[k])
    );
  end

  // at most one cell bumps; none when the carry leaves the top digit
  always_comb begin
    delta_sel = '0;
    for (int k = 0; k < DIGITS; k++) begin
      if (bump[k]) begin
        delta_sel = delta_sel | delta_tab[k];
      end
    end
    if (carry[DIGITS-1]) begin
      delta_sel = delta_sel | delta_tab[DIGITS];
    end
  end

  // during rotation cell 0 holds digit number cnt
  assign wt_sel = wt_tab[cnt[IDX_W-1:0]];
  assign prod   = {{DIGIT_W{1'b0}}, wt_sel} * {{FRAC_BITS{1'b0}}, digit[0]};

  always_comb begin
    sum_nxt = sum_r;
    case (ctl.mode)
      CELL_CLEAR: begin
        sum_nxt = '0;
      end
      CELL_INC: begin
        sum_nxt = sum_r + delta_sel;
      end
      CELL_ROTATE: begin
        if (rot_en) begin
          sum_nxt = sum_r + prod[FRAC_BITS-1:0];
        end
      end
      default: begin
        sum_nxt = sum_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

[design/halton_point_generator_core.sv]
`timescale 1ns / 1ps
// top level of the 3-d halton point generator (bases 2, 3 and 5)
//
// Each input transaction returns one point: the sequence index and its base-2, base-3 and
// base-5 radical inverses as unsigned Q0.FRACTION_BITS fractions. In a step the base-3 and
// base-5 digit rows increment through their carry chains and the coordinate sums change by
// one table value each. In a seek the index is fed msb first into both digit rows, one bit
// per cycle, and then the rows rotate once through their cells while the sums gather one
// weighted digit per cycle. A new transaction is taken once the previous result has been
// taken, or in the same cycle. Stepping past the largest index restarts the sequence at
// zero.
module halton_point_generator_core #(
  parameter int INDEX_BITS     = 32,
  parameter int TERNARY_DIGITS = 21,
  parameter int QUINARY_DIGITS = 14,
  parameter int FRACTION_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // seek_index
  input  logic [0:0]   in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // point_index, x_fraction, y_fraction, z_fraction
);
  import hpg_pkg::*;

  localparam int MAX_DIGITS = (TERNARY_DIGITS > QUINARY_DIGITS) ? TERNARY_DIGITS
                                                                 : QUINARY_DIGITS;
  localparam int CNT_MAX    = (INDEX_BITS > MAX_DIGITS) ? INDEX_BITS : MAX_DIGITS;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);
  localparam int REV_BITS   = (INDEX_BITS < FRACTION_BITS) ? INDEX_BITS : FRACTION_BITS;

  seq_state_t state_r, state_nxt;
  logic [INDEX_BITS-1:0] index_r, index_nxt;
  logic [INDEX_BITS-1:0] conv_r, conv_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  result_set;
  logic                  in_fire;
  chain_ctl_t            ctl;

  logic [FRACTION_BITS-1:0] x_frac;
  logic [FRACTION_BITS-1:0] y_sum;
  logic [FRACTION_BITS-1:0] z_sum;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    index_nxt     = index_r;
    conv_nxt      = conv_r;
    cnt_nxt       = cnt_r;
    result_set    = 1'b0;
    ctl.mode      = CELL_HOLD;
    ctl.shift_bit = conv_r[INDEX_BITS-1];
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == CMD_SEEK) begin
            index_nxt = in_tdata[INDEX_BITS-1:0];
            conv_nxt  = in_tdata[INDEX_BITS-1:0];
            cnt_nxt   = '0;
            ctl.mode  = CELL_CLEAR;
            state_nxt = ST_CONV;
          end else begin
            result_set = 1'b1;
            if (index_r == '1) begin
              // index wrap restarts the whole sequence
              index_nxt = '0;
              ctl.mode  = CELL_CLEAR;
            end else begin
              index_nxt = index_r + INDEX_BITS'(1);
              ctl.mode  = CELL_INC;
            end
          end
        end
      end
      ST_CONV: begin
        ctl.mode = CELL_DOUBLE;
        conv_nxt = conv_r << 1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(INDEX_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        ctl.mode = CELL_ROTATE;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAX_DIGITS - 1)) begin
          cnt_nxt    = '0;
          result_set = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = result_set || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      index_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      index_r     <= index_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    conv_r <= conv_nxt;
  end

  hpg_digit_chain #(
    .BASE      (TERN_BASE),
    .DIGITS    (TERNARY_DIGITS),
    .DIGIT_W   (2),
    .FRAC_BITS (FRACTION_BITS),
    .CNT_W     (CNT_W)
  ) u_tern_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cnt   (cnt_r),
    .sum   (y_sum)
  );

  hpg_digit_chain #(
    .BASE      (QUIN_BASE),
    .DIGITS    (QUINARY_DIGITS),
    .DIGIT_W   (3),
    .FRAC_BITS (FRACTION_BITS),
    .CNT_W     (CNT_W)
  ) u_quin_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cnt   (cnt_r),
    .sum   (z_sum)
  );

  // base 2 radical inverse is the index mirrored about the binary point
  always_comb begin
    x_frac = '0;
    for (int k = 0; k < REV_BITS; k++) begin
      x_frac[FRACTION_BITS-1-k] = index_r[k];
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_tdata[31:0]  = 32'(index_r);
  assign out_tdata[63:32] = 32'(x_frac);
  assign out_tdata[95:64] = 32'(y_sum);
  assign out_tdata[127:96] = 32'(z_sum);

endmodule

[design/hpg_checker.sv]
`timescale 1ns / 1ps
// port-level assertions for the halton point generator and their bind
module hpg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [0:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // no new transaction while a result is stuck
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  // a step answers in the next cycle
  a_step_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == 1'b0) |=> out_tvalid)
    else $error("step result missing");

  // consecutive step results advance the index by one or restart at zero
  a_step_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && in_tvalid && in_tready && (in_tuser[0] == 1'b0) |=>
      (out_tdata[31:0] == $past(out_tdata[31:0]) + 32'd1) || (out_tdata[31:0] == 32'd0))
    else $error("step index not consecutive");

  // index zero has all coordinates at zero
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] == 32'd0) |-> (out_tdata[127:32] == 96'd0))
    else $error("nonzero coordinates at index zero");

endmodule

bind halton_point_generator_core hpg_checker u_hpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/halton_point_generator_core_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the halton point generator core
module halton_point_generator_core_test;
  import hpg_pkg::*;

  localparam int INDEX_BITS     = 32;
  localparam int TERNARY_DIGITS = 21;
  localparam int QUINARY_DIGITS = 14;
  localparam int FRACTION_BITS  = 32;
  localparam int RANDOM_ITEMS   = 600;
  localparam int TAIL_ITEMS     = 40;
  localparam int DRAIN_CYCLES   = 80;
  localparam int STALL_LIMIT    = 4000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] seek_index;
  } point_cmd_t;

  typedef struct packed {
    logic [31:0] z_fraction;
    logic [31:0] y_fraction;
    logic [31:0] x_fraction;
    logic [31:0] point_index;
  } halton_point_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;   // seek_index
  logic [0:0]   in_tuser = '0;   // cmd
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // point_index, x_fraction, y_fraction, z_fraction

  point_cmd_t    cmd_queue[$];
  halton_point_t expected_points[$];
  int            total_items;
  int            accepted_count = 0;
  int            error_count = 0;
  int            quiet_cycles = 0;

  // shadow state of the generator
  logic [31:0] shadow_index;
  logic [1:0]  shadow_tern[TERNARY_DIGITS];
  logic [2:0]  shadow_quin[QUINARY_DIGITS];
  logic [31:0] shadow_y_sum;
  logic [31:0] shadow_z_sum;

  // driver and receiver idling
  int gap_left = 0;
  bit gaps_on = 1'b1;
  int stall_left = 0;
  bit stalls_on = 1'b1;

  halton_point_generator_core #(
    .INDEX_BITS(INDEX_BITS),
    .TERNARY_DIGITS(TERNARY_DIGITS),
    .QUINARY_DIGITS(QUINARY_DIGITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  // floor(2^FRACTION_BITS / base^(pos+1)), zero once the power passes 2^FRACTION_BITS
  function automatic logic [63:0] radix_weight(input int base, input int pos);
    logic [63:0] p;
    p = 64'(base);
    for (int i = 0; i < pos; i++) begin
      if (p <= (64'd1 << FRACTION_BITS)) begin
        p = p * 64'(base);
      end
    end
    return (64'd1 << FRACTION_BITS) / p;
  endfunction

  task automatic clear_shadow();
    shadow_index = '0;
    foreach (shadow_tern[k]) shadow_tern[k] = '0;
    foreach (shadow_quin[k]) shadow_quin[k] = '0;
    shadow_y_sum = '0;
    shadow_z_sum = '0;
  endtask

  // apply one command to the shadow state and form the point it returns
  task automatic advance_halton(input point_cmd_t c, output halton_point_t p);
    logic [63:0] next_index;
    logic [63:0] rest;
    logic [63:0] acc;
    logic [63:0] d;
    bit          carried;
    if (c.cmd == CMD_STEP) begin
      next_index = (64'(shadow_index) + 64'd1) & ((64'd1 << INDEX_BITS) - 64'd1);
      if (next_index == 64'd0) begin
        clear_shadow();
      end else begin
        shadow_index = next_index[31:0];
        carried = 1'b0;
        for (int k = 0; k < TERNARY_DIGITS; k++) begin
          if (!carried) begin
            if (shadow_tern[k] == 2'(TERN_BASE - 1)) begin
              shadow_y_sum = shadow_y_sum - 32'(64'(TERN_BASE - 1) * radix_weight(TERN_BASE, k));
              shadow_tern[k] = '0;
            end else begin
              shadow_tern[k] = shadow_tern[k] + 2'd1;
              shadow_y_sum = shadow_y_sum + 32'(radix_weight(TERN_BASE, k));
              carried = 1'b1;
            end
          end
        end
        carried = 1'b0;
        for (int k = 0; k < QUINARY_DIGITS; k++) begin
          if (!carried) begin
            if (shadow_quin[k] == 3'(QUIN_BASE - 1)) begin
              shadow_z_sum = shadow_z_sum - 32'(64'(QUIN_BASE - 1) * radix_weight(QUIN_BASE, k));
              shadow_quin[k] = '0;
            end else begin
              shadow_quin[k] = shadow_quin[k] + 3'd1;
              shadow_z_sum = shadow_z_sum + 32'(radix_weight(QUIN_BASE, k));
              carried = 1'b1;
            end
          end
        end
      end
    end else begin
      shadow_index = 32'(64'(c.seek_index) & ((64'd1 << INDEX_BITS) - 64'd1));
      rest = 64'(shadow_index);
      acc = '0;
      for (int k = 0; k < TERNARY_DIGITS; k++) begin
        d = rest % TERN_BASE;
        rest = rest / TERN_BASE;
        shadow_tern[k] = d[1:0];
        acc = acc + d * radix_weight(TERN_BASE, k);
      end
      shadow_y_sum = acc[31:0];
      rest = 64'(shadow_index);
      acc = '0;
      for (int k = 0; k < QUINARY_DIGITS; k++) begin
        d = rest % QUIN_BASE;
        rest = rest / QUIN_BASE;
        shadow_quin[k] = d[2:0];
        acc = acc + d * radix_weight(QUIN_BASE, k);
      end
      shadow_z_sum = acc[31:0];
    end
    p.point_index = shadow_index;
    p.x_fraction = '0;
    for (int k = 0; k < INDEX_BITS && k < FRACTION_BITS; k++) begin
      p.x_fraction[FRACTION_BITS - 1 - k] = shadow_index[k];
    end
    p.y_fraction = shadow_y_sum;
    p.z_fraction = shadow_z_sum;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %0t: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic push_cmd(input logic cmd, input logic [31:0] seek_index);
    point_cmd_t c;
    c.cmd = cmd;
    c.seek_index = seek_index;
    cmd_queue.push_back(c);
  endtask

  // index just below a multiple of a power of the base, to drive long carry chains
  function automatic logic [31:0] near_power(input int base, input int max_exp);
    logic [63:0] p;
    p = 64'd1;
    for (int i = $urandom_range(1, max_exp); i > 0; i--) begin
      p = p * 64'(base);
    end
    p = p * 64'($urandom_range(1, base - 1)) - 64'($urandom_range(1, 3));
    return p[31:0];
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if ($urandom_range(0, 31) == 0) begin
        gaps_on = ~gaps_on;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_queue.size() > TAIL_ITEMS && gaps_on && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          point_cmd_t c;
          c = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= c.cmd;
          in_tdata <= c.seek_index;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 31) == 0) begin
        stalls_on = ~stalls_on;
      end
      if (cmd_queue.size() <= TAIL_ITEMS) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        point_cmd_t    c;
        halton_point_t p;
        c.cmd = in_tuser[0];
        c.seek_index = in_tdata;
        advance_halton(c, p);
        expected_points.push_back(p);
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        halton_point_t got;
        halton_point_t want;
        got = out_tdata;
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected point_index", got.point_index, '0);
        end else begin
          want = expected_points.pop_front();
          if (got.point_index !== want.point_index)
            report_mismatch("point_index", got.point_index, want.point_index);
          if (got.x_fraction !== want.x_fraction)
            report_mismatch("x_fraction", got.x_fraction, want.x_fraction);
          if (got.y_fraction !== want.y_fraction)
            report_mismatch("y_fraction", got.y_fraction, want.y_fraction);
          if (got.z_fraction !== want.z_fraction)
            report_mismatch("z_fraction", got.z_fraction, want.z_fraction);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int count;
    int steps;
    int pick;
    logic [31:0] start;
    clear_shadow();

    // directed: first points from reset, extremes, wrap and long carries
    push_cmd(CMD_STEP, 32'hFFFFFFFF);
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_SEEK, 32'h0);
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_SEEK, 32'hFFFFFFFF);
    push_cmd(CMD_STEP, 32'h12345678);   // index wrap to zero
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_SEEK, 32'd3486784400); // 3^20 - 1: the low 20 ternary digits carry
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_SEEK, 32'd1220703124); // 5^13 - 1: the low 13 quinary digits carry
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_SEEK, 32'hFFFFFFFE);
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_SEEK, 32'h55555555);
    push_cmd(CMD_SEEK, 32'hAAAAAAAA);
    push_cmd(CMD_SEEK, 32'h80000000);
    push_cmd(CMD_STEP, 32'h0);
    push_cmd(CMD_SEEK, 32'd3486784401); // top ternary digit set, its weight is below resolution
    push_cmd(CMD_STEP, 32'h0);

    // random: mostly a seek followed by a run of steps, some loose commands
    count = 0;
    while (count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        case ($urandom_range(0, 3))
          0: start = $urandom();
          1: start = 32'hFFFFFFFF - 32'($urandom_range(0, 8));
          2: start = near_power(TERN_BASE, 20);
          default: start = near_power(QUIN_BASE, 13);
        endcase
        push_cmd(CMD_SEEK, start);
        steps = $urandom_range(1, 12);
        for (int i = 0; i < steps; i++) begin
          push_cmd(CMD_STEP, $urandom());
        end
        count += steps + 1;
      end else begin
        push_cmd(logic'($urandom_range(0, 1)), $urandom());
        count++;
      end
    end
    total_items = cmd_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_items || expected_points.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_points.size() > 0) begin
      report_mismatch("missing point_index", '0, expected_points[0].point_index);
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
